### design/qenc_pkg.sv
// Shared types and constants for the quadrature encoder PWM setpoint block.
// Holds the decoder state enum, step codes, register indexes and payload structs.
// No dependencies.
package qenc_pkg;

	// Decoder states of the full-cycle quadrature machine
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_C01  = 3'd1,
		ST_C00  = 3'd2,
		ST_C10  = 3'd3,
		ST_D10  = 3'd4,
		ST_D00  = 3'd5,
		ST_D01  = 3'd6
	} qenc_state_t;

	// Step direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// Which encoder line produced the edge
	localparam logic LINE_CLK = 1'b0;
	localparam logic LINE_DT  = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CENTER = 2'd2;

	// Register reset values
	localparam logic [15:0] PWM_TOP_RST     = 16'd799;
	localparam logic [9:0]  DUTY_STEP_RST   = 10'd18;
	localparam logic [15:0] DUTY_CENTER_RST = 16'd400;

	// Product of duty step and position: 11-bit signed by 16-bit signed
	localparam int unsigned PROD_W = 27;

	typedef struct packed {
		logic mode;
		logic level;
	} qenc_in_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic [1:0]         step_dir;
		logic [15:0]        compare_value;
		logic [2:0]         fsm_code;
	} qenc_out_t;

	// Decoder result handed from the state machine to the pipeline
	typedef struct packed {
		qenc_state_t        state;
		logic [1:0]         dir;
		logic signed [15:0] position;
	} qenc_dec_t;

endpackage

### design/qenc_decoder.sv
// Quadrature state machine and wrapping position counter.
// Depends on qenc_pkg for the state enum, step codes and structs.
module qenc_decoder
	import qenc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  qenc_in_t  ev,
	output qenc_dec_t dec
);

	qenc_state_t        state_q;
	qenc_state_t        state_next;
	logic signed [15:0] position_q;
	logic [1:0]         dir;
	logic signed [15:0] position_next;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ev.mode == LINE_CLK && !ev.level)
					state_next = ST_C01;
				else if (ev.mode == LINE_DT && !ev.level)
					state_next = ST_D10;
			end
			ST_C01: begin
				if (ev.mode == LINE_CLK && ev.level)
					state_next = ST_IDLE;
				else if (ev.mode == LINE_DT && !ev.level)
					state_next = ST_C00;
			end
			ST_C00: begin
				if (ev.mode == LINE_CLK && ev.level)
					state_next = ST_C10;
				else if (ev.mode == LINE_DT && ev.level)
					state_next = ST_C01;
			end
			ST_C10: begin
				if (ev.mode == LINE_CLK && !ev.level)
					state_next = ST_C00;
				else if (ev.mode == LINE_DT && ev.level)
					state_next = ST_IDLE;
			end
			ST_D10: begin
				if (ev.mode == LINE_CLK && !ev.level)
					state_next = ST_D00;
				else if (ev.mode == LINE_DT && ev.level)
					state_next = ST_IDLE;
			end
			ST_D00: begin
				if (ev.mode == LINE_CLK && ev.level)
					state_next = ST_D10;
				else if (ev.mode == LINE_DT && ev.level)
					state_next = ST_D01;
			end
			ST_D01: begin
				if (ev.mode == LINE_CLK && ev.level)
					state_next = ST_IDLE;
				else if (ev.mode == LINE_DT && !ev.level)
					state_next = ST_D00;
			end
			default: state_next = state_q;
		endcase
	end

	// Outputs: a step completes only when a full cycle closes back to idle
	always_comb begin
		dir = DIR_NONE;
		if (state_q == ST_C10 && ev.mode == LINE_DT && ev.level)
			dir = DIR_UP;
		else if (state_q == ST_D01 && ev.mode == LINE_CLK && ev.level)
			dir = DIR_DOWN;

		position_next = position_q;
		if (dir == DIR_UP)
			position_next = position_q + 16'sd1;
		else if (dir == DIR_DOWN)
			position_next = position_q - 16'sd1;

		dec.state    = state_next;
		dec.dir      = dir;
		dec.position = position_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			position_q <= 16'sd0;
		end else if (adv) begin
			state_q    <= state_next;
			position_q <= position_next;
		end
	end

endmodule

### design/qenc_compare.sv
// Offset and saturation of the duty product into the PWM compare range.
// Depends on qenc_pkg for the product width.
module qenc_compare
	import qenc_pkg::*;
(
	input  logic signed [PROD_W-1:0] prod,
	input  logic [15:0]              center,
	input  logic [15:0]              top,
	output logic [15:0]              value
);

	logic signed [PROD_W:0] sum;

	assign sum = $signed({prod[PROD_W-1], prod})
		+ $signed({{(PROD_W-15){1'b0}}, center});

	// Clamp below at zero, above at top
	always_comb begin
		if (sum[PROD_W])
			value = 16'd0;
		else if (sum[PROD_W-1:0] > {{(PROD_W-16){1'b0}}, top})
			value = top;
		else
			value = sum[15:0];
	end

endmodule

### design/quadrature_encoder_pwm_setpoint.sv
// Top level of the quadrature encoder decoder with PWM compare setpoint.
// Depends on qenc_pkg, qenc_decoder and qenc_compare.
//
//   channel  direction  handshake              payload
//   evt      in         evt_valid / evt_stall  qenc_in_t  {mode, level}
//   res      out        res_valid / res_stall  qenc_out_t {position, step_dir,
//                                                          compare_value, fsm_code}
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One edge event per cycle while res is not stalled; an accepted event passes the
// input register, then decode and multiply into stage 2, then offset and clamp
// into the result register.
// The decoder state and count advance once per event, leaving the product
// multiply as the only wide path of that stage.
// arst_n clears the decoder to idle with a zero count and loads register defaults.
// A stall on res holds the result; earlier stages keep filling bubbles and
// stall evt only once every stage holds a transaction.
module quadrature_encoder_pwm_setpoint
	import qenc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  qenc_in_t             evt,

	output logic                 res_valid,
	input  logic                 res_stall,
	output qenc_out_t            res,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// Configuration registers
	logic [15:0] pwm_top_q;
	logic [9:0]  duty_step_q;
	logic [15:0] duty_center_q;

	// Stage 1: input register
	logic     valid_s1;
	qenc_in_t evt_s1;

	// Stage 2: decoded event and duty product
	logic                     valid_s2;
	qenc_state_t              state_s2;
	logic [1:0]               dir_s2;
	logic signed [15:0]       position_s2;
	logic signed [PROD_W-1:0] prod_s2;

	// Result register
	logic      res_valid_q;
	qenc_out_t res_q;

	logic                     out_free;
	logic                     s2_free;
	logic                     s1_free;
	logic                     dec_adv;
	qenc_dec_t                dec;
	logic signed [PROD_W-1:0] prod;
	logic [15:0]              cmp_value;

	// Each stage takes a new transaction when it is empty or is handing off
	assign out_free  = !res_valid_q || !res_stall;
	assign s2_free   = !valid_s2 || out_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign dec_adv   = valid_s1 && s2_free;
	assign evt_stall = !s1_free;
	assign cfg_ready = 1'b1;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q     <= PWM_TOP_RST;
			duty_step_q   <= DUTY_STEP_RST;
			duty_center_q <= DUTY_CENTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PWM_TOP:     pwm_top_q     <= cfg_data;
				CFG_DUTY_STEP:   duty_step_q   <= cfg_data[9:0];
				CFG_DUTY_CENTER: duty_center_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: capture the edge event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= evt_valid;
	end

	always_ff @(posedge clk) begin
		if (s1_free && evt_valid)
			evt_s1 <= evt;
	end

	// Walk the quadrature machine and update the count
	qenc_decoder u_decoder (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (dec_adv),
		.ev     (evt_s1),
		.dec    (dec)
	);

	// Duty product uses the count after this event
	assign prod = $signed({1'b0, duty_step_q}) * dec.position;

	// Stage 2: hold decoded fields and product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (dec_adv) begin
			state_s2    <= dec.state;
			dir_s2      <= dec.dir;
			position_s2 <= dec.position;
			prod_s2     <= prod;
		end
	end

	// Add center and clamp to 0..pwm_top
	qenc_compare u_compare (
		.prod   (prod_s2),
		.center (duty_center_q),
		.top    (pwm_top_q),
		.value  (cmp_value)
	);

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			res_q.position      <= position_s2;
			res_q.step_dir      <= dir_s2;
			res_q.compare_value <= cmp_value;
			res_q.fsm_code      <= state_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
